### hdl/cses_pkg.sv
// cses_pkg: shared types, codes and the quadrature step table of the
// control surface event scanner; no dependencies
`default_nettype none

package cses_pkg;

  typedef enum logic [1:0] {
    CMD_POT       = 2'd0,
    CMD_BUTTON    = 2'd1,
    CMD_JOG_PHASE = 2'd2,
    CMD_JOG_FLUSH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    EV_POT            = 2'd0,
    EV_BUTTON_PRESS   = 2'd1,
    EV_BUTTON_RELEASE = 2'd2,
    EV_JOG_STEP       = 2'd3
  } event_kind_t;

  typedef enum logic [1:0] {
    REG_POT_INTERVAL  = 2'd0,
    REG_POT_DEADBAND  = 2'd1,
    REG_DEBOUNCE      = 2'd2,
    REG_BUTTON_ENABLE = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FLUSH
  } scan_state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  source_index;
    logic [11:0] sample;
    logic [31:0] now_ms;
  } scan_in_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [4:0] source_number;
    logic [6:0] event_value;
    logic       last_of_run;
  } scan_out_t;

  localparam logic [15:0] POT_INTERVAL_RESET = 16'd5;
  localparam logic [6:0]  POT_DEADBAND_RESET = 7'd2;
  localparam logic [15:0] DEBOUNCE_RESET     = 16'd20;
  localparam logic [7:0]  POT_NONE_SENT      = 8'hFF;  // -1
  localparam logic [6:0]  VALUE_PRESS        = 7'd127;
  localparam logic [6:0]  VALUE_RELEASE      = 7'd0;
  localparam logic [6:0]  VALUE_JOG_CW       = 7'd1;
  localparam logic [6:0]  VALUE_JOG_CCW      = 7'd127;

  // step for previous and current AB; clockwise order 00,10,11,01
  function automatic logic signed [1:0] quad_step(input logic [1:0] prev,
                                                  input logic [1:0] cur);
    logic signed [1:0] s;
    s = 2'sd0;
    case ({prev, cur})
      4'b00_01: s = -2'sd1;
      4'b00_10: s = 2'sd1;
      4'b01_00: s = 2'sd1;
      4'b01_11: s = -2'sd1;
      4'b10_00: s = -2'sd1;
      4'b10_11: s = 2'sd1;
      4'b11_01: s = 2'sd1;
      4'b11_10: s = -2'sd1;
      default:  s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### hdl/control_surface_event_scanner_top.sv
// control_surface_event_scanner_top: pot, button and jog event scanner
// depends on cses_pkg and cses_ram
// pot, button and jog phase items are accepted in ST_IDLE, then ST_EVAL does the
//   read-modify-write of the per-source memory entry, waiting, when it has a result,
//   while the output register is full; a result sits in the output register from the
//   cycle after the read-modify-write; a new item is taken only in ST_IDLE, once the
//   last is through; a jog flush sends its step items one per cycle while output is free
// reset: synchronous; config registers take their defaults, valid bits of both
//   memories clear at once (no clearing pass), jog state and handshakes clear
`default_nettype none

module control_surface_event_scanner_top #(
  parameter int POT_COUNT     = 16,
  parameter int BUTTON_COUNT  = 32,
  parameter int MAX_JOG_BURST = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  // input channel
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire cses_pkg::scan_in_t cmd_item,
  // output channel
  output logic                    event_valid,
  input  wire logic               event_ready,
  output cses_pkg::scan_out_t     event_item
);

  import cses_pkg::*;

  localparam int POT_AW   = (POT_COUNT > 1) ? $clog2(POT_COUNT) : 1;
  localparam int BTN_AW   = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int BURST_W  = $clog2(MAX_JOG_BURST + 1);
  localparam int POT_W    = 40;  // last value (8) + last report time (32)
  localparam int BTN_W    = 34;  // stable, raw, change time (32)
  localparam logic signed [31:0] BURST_MAX = 32'(MAX_JOG_BURST);
  localparam logic signed [31:0] JOG_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] JOG_MIN   = 32'sh8000_0000;

  // configuration registers
  logic [15:0] pot_interval_ms;
  logic [6:0]  pot_deadband;
  logic [15:0] btn_hold_ms;
  logic [31:0] button_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      pot_interval_ms <= POT_INTERVAL_RESET;
      pot_deadband    <= POT_DEADBAND_RESET;
      btn_hold_ms     <= DEBOUNCE_RESET;
      button_enable   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POT_INTERVAL:  pot_interval_ms <= cfg_data[15:0];
        REG_POT_DEADBAND:  pot_deadband    <= cfg_data[6:0];
        REG_DEBOUNCE:      btn_hold_ms     <= cfg_data[15:0];
        REG_BUTTON_ENABLE: button_enable   <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state
  scan_state_t       state, state_next;
  scan_in_t          item_q;
  logic              cmd_accept;
  logic              out_free;
  logic              out_load;
  scan_out_t         out_next;

  // jog state lives in flops: one entry only
  logic [1:0]        jog_phase, jog_phase_next;
  logic signed [31:0] jog_count, jog_count_next;
  logic [BURST_W-1:0] burst_left, burst_left_next;
  logic              burst_cw, burst_cw_next;

  // per-entry valid bits; an entry never written reads as its reset value
  logic [POT_COUNT-1:0]    pot_valid;
  logic [BUTTON_COUNT-1:0] btn_valid;

  // memory ports
  logic [4:0]         rd_index;
  logic [POT_AW-1:0]  pot_addr, pot_raddr;
  logic [BTN_AW-1:0]  btn_addr, btn_raddr;
  logic [POT_W-1:0]   pot_rdata, pot_wdata;
  logic [BTN_W-1:0]   btn_rdata, btn_wdata;
  logic               pot_we, btn_we;

  assign cmd_ready  = (state == ST_IDLE);
  assign cmd_accept = cmd_valid && cmd_ready;
  assign out_free   = !event_valid || event_ready;

  // address from the input while idle, else from the held item so the
  // read data stays put while a result waits for the output register
  assign rd_index  = (state == ST_IDLE) ? cmd_item.source_index : item_q.source_index;
  assign pot_raddr = rd_index[POT_AW-1:0];
  assign btn_raddr = rd_index[BTN_AW-1:0];
  assign pot_addr  = item_q.source_index[POT_AW-1:0];
  assign btn_addr  = item_q.source_index[BTN_AW-1:0];

  cses_ram #(.WIDTH(POT_W), .DEPTH(POT_COUNT)) u_pot_ram (
    .clk   (clk),
    .we    (pot_we),
    .waddr (pot_addr),
    .wdata (pot_wdata),
    .raddr (pot_raddr),
    .rdata (pot_rdata)
  );

  cses_ram #(.WIDTH(BTN_W), .DEPTH(BUTTON_COUNT)) u_btn_ram (
    .clk   (clk),
    .we    (btn_we),
    .waddr (btn_addr),
    .wdata (btn_wdata),
    .raddr (btn_raddr),
    .rdata (btn_rdata)
  );

  // pot evaluation
  logic               pot_in_range;
  logic [7:0]         pot_last_value;
  logic [31:0]        pot_last_time;
  logic [31:0]        pot_elapsed;
  logic [6:0]         pot_value;
  logic signed [8:0]  pot_diff;
  logic [7:0]         pot_abs;
  logic               pot_fire;

  assign pot_in_range   = 32'(item_q.source_index) < 32'(POT_COUNT);
  assign pot_last_value = pot_valid[pot_addr] ? pot_rdata[39:32] : POT_NONE_SENT;
  assign pot_last_time  = pot_valid[pot_addr] ? pot_rdata[31:0] : 32'd0;
  assign pot_elapsed    = item_q.now_ms - pot_last_time;
  assign pot_value      = item_q.sample[11:5];
  assign pot_diff       = $signed({2'b00, pot_value}) - $signed({pot_last_value[7], pot_last_value});
  assign pot_abs        = pot_diff[8] ? 8'(-pot_diff) : pot_diff[7:0];
  assign pot_fire       = pot_in_range && (pot_elapsed >= {16'd0, pot_interval_ms})
                          && (pot_abs >= {1'b0, pot_deadband});
  assign pot_wdata      = {1'b0, pot_value, item_q.now_ms};

  // button evaluation
  logic        btn_active;
  logic        btn_level;
  logic        btn_stable, btn_raw;
  logic [31:0] btn_time, btn_time_new;
  logic [31:0] btn_elapsed;
  logic        btn_fire;

  assign btn_active   = (32'(item_q.source_index) < 32'(BUTTON_COUNT))
                        && button_enable[item_q.source_index];
  assign btn_level    = item_q.sample[0];
  assign btn_stable   = btn_valid[btn_addr] ? btn_rdata[33] : 1'b1;
  assign btn_raw      = btn_valid[btn_addr] ? btn_rdata[32] : 1'b1;
  assign btn_time     = btn_valid[btn_addr] ? btn_rdata[31:0] : 32'd0;
  assign btn_time_new = (btn_level != btn_raw) ? item_q.now_ms : btn_time;
  assign btn_elapsed  = item_q.now_ms - btn_time_new;
  assign btn_fire     = (btn_elapsed >= {16'd0, btn_hold_ms}) && (btn_level != btn_stable);
  assign btn_wdata    = {(btn_fire ? btn_level : btn_stable), btn_level, btn_time_new};

  // jog step with saturation, and the size of a flush burst
  logic signed [1:0]  jog_step;
  logic signed [31:0] jog_stepped;
  logic [31:0]        jog_neg;
  logic [BURST_W-1:0] burst_size;

  assign jog_step = quad_step(jog_phase, item_q.sample[1:0]);

  always_comb begin
    jog_stepped = jog_count + 32'(jog_step);
    if (jog_step == 2'sd1 && jog_count == JOG_MAX) begin
      jog_stepped = JOG_MAX;
    end else if (jog_step == -2'sd1 && jog_count == JOG_MIN) begin
      jog_stepped = JOG_MIN;
    end
  end

  assign jog_neg = 32'(-jog_count);

  always_comb begin
    if (jog_count > BURST_MAX || jog_count < -BURST_MAX) begin
      burst_size = BURST_W'(MAX_JOG_BURST);
    end else if (jog_count < 0) begin
      burst_size = jog_neg[BURST_W-1:0];
    end else begin
      burst_size = jog_count[BURST_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    jog_phase_next  = jog_phase;
    jog_count_next  = jog_count;
    burst_left_next = burst_left;
    burst_cw_next   = burst_cw;
    pot_we          = 1'b0;
    btn_we          = 1'b0;
    out_load        = 1'b0;
    out_next        = '0;
    case (state)
      ST_IDLE: begin
        if (cmd_accept) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        case (item_q.cmd)
          CMD_POT: begin
            if (!pot_fire) begin
              state_next = ST_IDLE;
            end else if (out_free) begin
              pot_we     = 1'b1;
              out_load   = 1'b1;
              out_next   = '{event_kind: EV_POT, source_number: item_q.source_index,
                             event_value: pot_value, last_of_run: 1'b1};
              state_next = ST_IDLE;
            end
          end
          CMD_BUTTON: begin
            if (!btn_active) begin
              state_next = ST_IDLE;
            end else if (!btn_fire) begin
              btn_we     = 1'b1;  // raw level and change time may move
              state_next = ST_IDLE;
            end else if (out_free) begin
              btn_we     = 1'b1;
              out_load   = 1'b1;
              out_next   = '{event_kind: (btn_level ? EV_BUTTON_RELEASE : EV_BUTTON_PRESS),
                             source_number: item_q.source_index,
                             event_value: (btn_level ? VALUE_RELEASE : VALUE_PRESS),
                             last_of_run: 1'b1};
              state_next = ST_IDLE;
            end
          end
          CMD_JOG_PHASE: begin
            jog_count_next = jog_stepped;
            jog_phase_next = item_q.sample[1:0];
            state_next     = ST_IDLE;
          end
          CMD_JOG_FLUSH: begin
            if (jog_count == 32'sd0) begin
              state_next = ST_IDLE;
            end else begin
              burst_left_next = burst_size;
              burst_cw_next   = (jog_count > 0);
              state_next      = ST_FLUSH;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_FLUSH: begin
        // one step item a cycle while the output register is free; the count walks toward zero as they go
        if (out_free) begin
          out_load        = 1'b1;
          out_next        = '{event_kind: EV_JOG_STEP, source_number: 5'd0,
                              event_value: (burst_cw ? VALUE_JOG_CW : VALUE_JOG_CCW),
                              last_of_run: (burst_left == BURST_W'(1))};
          jog_count_next  = burst_cw ? jog_count - 32'sd1 : jog_count + 32'sd1;
          burst_left_next = burst_left - BURST_W'(1);
          if (burst_left == BURST_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      jog_phase  <= 2'd0;
      jog_count  <= 32'sd0;
      burst_left <= '0;
      burst_cw   <= 1'b0;
      pot_valid  <= '0;
      btn_valid  <= '0;
    end else begin
      state      <= state_next;
      jog_phase  <= jog_phase_next;
      jog_count  <= jog_count_next;
      burst_left <= burst_left_next;
      burst_cw   <= burst_cw_next;
      if (pot_we) begin
        pot_valid[pot_addr] <= 1'b1;
      end
      if (btn_we) begin
        btn_valid[btn_addr] <= 1'b1;
      end
    end
  end

  // held item
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      item_q <= cmd_item;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (out_load) begin
      event_valid <= 1'b1;
    end else if (event_ready) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      event_item <= out_next;
    end
  end

  // a burst in progress always has steps left
  assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH |-> burst_left != '0)
    else $error("flush state with empty burst");

  // pot and button items produce a single result, so it closes the run
  assert property (@(posedge clk) disable iff (rst)
    event_valid && event_item.event_kind != EV_JOG_STEP |-> event_item.last_of_run)
    else $error("single result without last_of_run");

  // each step item moves the jog count by exactly one toward zero
  assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH && out_free |=>
      (jog_count == $past(jog_count) - 32'sd1) || (jog_count == $past(jog_count) + 32'sd1))
    else $error("jog count not stepped by one during flush");

  // memory is written only while a fetched item is being evaluated
  assert property (@(posedge clk) disable iff (rst)
    (pot_we || btn_we) |-> state == ST_EVAL && !(pot_we && btn_we))
    else $error("memory write outside evaluation");

  // a loaded result never overwrites one still waiting
  assert property (@(posedge clk) disable iff (rst)
    out_load |-> !event_valid || event_ready)
    else $error("output register overrun");

endmodule

`default_nettype wire

### hdl/cses_ram.sv
// cses_ram: generic single-write, single-read memory with registered read
// no dependencies
`default_nettype none

module cses_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### tb/sv/control_surface_event_scanner_top_tb.sv
// control_surface_event_scanner_top_tb: self-checking bench for the event scanner,
// with an event predictor and scoreboard class and plain driver tasks
// depends on cses_pkg and control_surface_event_scanner_top
module control_surface_event_scanner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cses_pkg::*;

  localparam int POT_COUNT     = 16;
  localparam int BUTTON_COUNT  = 32;
  localparam int MAX_JOG_BURST = 64;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 220;
  // a pot, button or jog phase item is done once its evaluation state has passed
  localparam int SETTLE_CYCLES = 8;

  // predicts the events of every accepted item and checks the received ones in order
  class event_scoreboard;
    // configuration copy
    logic [15:0] interval_ms;
    logic [6:0]  deadband;
    logic [15:0] hold_ms;
    logic [31:0] button_on;
    // per-source state
    int          pot_value [POT_COUNT];
    logic [31:0] pot_time [POT_COUNT];
    logic        btn_stable [BUTTON_COUNT];
    logic        btn_raw [BUTTON_COUNT];
    logic [31:0] btn_time [BUTTON_COUNT];
    logic [1:0]  jog_ab;
    longint      jog_total;
    scan_out_t   pending_events[$];
    int          mismatches;
    int          checked;

    function new();
      interval_ms = POT_INTERVAL_RESET;
      deadband    = POT_DEADBAND_RESET;
      hold_ms     = DEBOUNCE_RESET;
      button_on   = '0;
      for (int i = 0; i < POT_COUNT; i++) begin
        pot_value[i] = -1;
        pot_time[i]  = '0;
      end
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        btn_stable[i] = 1'b1;
        btn_raw[i]    = 1'b1;
        btn_time[i]   = '0;
      end
      jog_ab     = 2'b00;
      jog_total  = 0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_reg(reg_index_t r, logic [31:0] d);
      case (r)
        REG_POT_INTERVAL:  interval_ms = d[15:0];
        REG_POT_DEADBAND:  deadband    = d[6:0];
        REG_DEBOUNCE:      hold_ms     = d[15:0];
        REG_BUTTON_ENABLE: button_on   = d;
        default: ;
      endcase
    endfunction

    // position on the clockwise cycle 00, 10, 11, 01
    function int wheel_pos(logic [1:0] ab);
      case (ab)
        2'b00:   return 0;
        2'b10:   return 1;
        2'b11:   return 2;
        default: return 3;
      endcase
    endfunction

    function void add_event(event_kind_t k, logic [4:0] src, logic [6:0] val, logic fin);
      scan_out_t ev;
      ev.event_kind    = k;
      ev.source_number = src;
      ev.event_value   = val;
      ev.last_of_run   = fin;
      pending_events.push_back(ev);
    endfunction

    function void note_item(scan_in_t it);
      logic [6:0] level;
      logic [4:0] idx;
      int         diff;
      int         d;
      longint     mag;
      int         n;
      idx = it.source_index;
      case (it.cmd)
        CMD_POT: begin
          if (idx < POT_COUNT) begin
            if (it.now_ms - pot_time[idx] >= 32'(interval_ms)) begin
              level = it.sample[11:5];
              diff  = int'(level) - pot_value[idx];
              if (diff < 0) diff = -diff;
              if (diff >= int'(deadband)) begin
                pot_value[idx] = int'(level);
                pot_time[idx]  = it.now_ms;
                add_event(EV_POT, idx, level, 1'b1);
              end
            end
          end
        end
        CMD_BUTTON: begin
          if (button_on[idx]) begin
            if (it.sample[0] != btn_raw[idx]) begin
              btn_raw[idx]  = it.sample[0];
              btn_time[idx] = it.now_ms;
            end
            if (it.now_ms - btn_time[idx] >= 32'(hold_ms) &&
                it.sample[0] != btn_stable[idx]) begin
              btn_stable[idx] = it.sample[0];
              if (it.sample[0] == 1'b0) add_event(EV_BUTTON_PRESS, idx, VALUE_PRESS, 1'b1);
              else add_event(EV_BUTTON_RELEASE, idx, VALUE_RELEASE, 1'b1);
            end
          end
        end
        CMD_JOG_PHASE: begin
          // one step forward or back on the cycle counts; a skipped edge or no move is zero
          d = (wheel_pos(it.sample[1:0]) - wheel_pos(jog_ab) + 4) % 4;
          if (d == 1) jog_total = jog_total + 1;
          else if (d == 3) jog_total = jog_total - 1;
          if (jog_total > 64'sd2147483647) jog_total = 64'sd2147483647;
          if (jog_total < -64'sd2147483648) jog_total = -64'sd2147483648;
          jog_ab = it.sample[1:0];
        end
        default: begin
          if (jog_total != 0) begin
            mag = (jog_total < 0) ? -jog_total : jog_total;
            n   = (mag > MAX_JOG_BURST) ? MAX_JOG_BURST : int'(mag);
            for (int k = 0; k < n; k++)
              add_event(EV_JOG_STEP, 5'd0, (jog_total > 0) ? VALUE_JOG_CW : VALUE_JOG_CCW,
                        k == n - 1);
            if (jog_total > 0) jog_total = jog_total - n;
            else jog_total = jog_total + n;
          end
        end
      endcase
    endfunction

    function void check_event(scan_out_t got);
      scan_out_t want;
      checked++;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("event %0d unexpected: kind %0d src %0d value %0d last %0d", checked,
                   got.event_kind, got.source_number, got.event_value, got.last_of_run);
        return;
      end
      want = pending_events.pop_front();
      if (got.event_kind !== want.event_kind || got.source_number !== want.source_number ||
          got.event_value !== want.event_value || got.last_of_run !== want.last_of_run) begin
        mismatches++;
        if (mismatches <= 10)
          $display("event %0d: expected kind %0d src %0d value %0d last %0d, got %0d %0d %0d %0d",
                   checked, want.event_kind, want.source_number, want.event_value,
                   want.last_of_run, got.event_kind, got.source_number, got.event_value,
                   got.last_of_run);
      end
    endfunction

    function int pending();
      return pending_events.size();
    endfunction
  endclass

  // clock, reset and block ports; the driven ones are known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  scan_in_t    cmd_item = '0;
  logic        event_valid;
  logic        event_ready = 1'b0;
  scan_out_t   event_item;

  event_scoreboard sb;

  // millisecond time stamp carried by the next item
  logic [31:0] clock_ms = '0;
  // current phase of the simulated jog wheel
  logic [1:0]  wheel_ab = 2'b00;
  // items sent so far
  int          items_counted = 0;
  // items still to send before the sender takes a gap
  int          burst_left = 0;
  int          cycle_count = 0;

  control_surface_event_scanner_top #(
    .POT_COUNT    (POT_COUNT),
    .BUTTON_COUNT (BUTTON_COUNT),
    .MAX_JOG_BURST(MAX_JOG_BURST)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_item   (cmd_item),
    .event_valid(event_valid),
    .event_ready(event_ready),
    .event_item (event_item)
  );

  always #5 clk = ~clk;

  // handshakes are sampled with the values from before the edge
  always @(posedge clk) begin
    if (!rst && cmd_valid && cmd_ready) sb.note_item(cmd_item);
    if (!rst && event_valid && event_ready) sb.check_event(event_item);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("control_surface_event_scanner_top: mismatch");
      $finish;
    end
  end

  // receiver: stretches of always ready, random stalls, a one-in-four pattern
  // and a pattern of long stalls
  initial begin : rx_pattern
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      for (int k = 0; k < span; k++) begin
        case (mode)
          0:       event_ready <= 1'b1;
          1:       event_ready <= 1'($urandom_range(0, 1));
          2:       event_ready <= (k % 4 == 3);
          default: event_ready <= (k % 16 >= 11);
        endcase
        @(posedge clk);
      end
    end
  end

  // next phase one step along the wheel
  function automatic logic [1:0] turn(input logic [1:0] ab, input logic cw);
    logic [1:0] nxt;
    if (cw) begin
      case (ab)
        2'b00:   nxt = 2'b10;
        2'b10:   nxt = 2'b11;
        2'b11:   nxt = 2'b01;
        default: nxt = 2'b00;
      endcase
    end else begin
      case (ab)
        2'b00:   nxt = 2'b01;
        2'b01:   nxt = 2'b11;
        2'b11:   nxt = 2'b10;
        default: nxt = 2'b00;
      endcase
    end
    return nxt;
  endfunction

  // present one item, hold it until accepted, then maybe take a gap
  task automatic send_item(input cmd_t c, input logic [4:0] idx, input logic [11:0] smp);
    scan_in_t it;
    int       r;
    it.cmd          = c;
    it.source_index = idx;
    it.sample       = smp;
    it.now_ms       = clock_ms;
    items_counted++;
    cmd_valid <= 1'b1;
    cmd_item  <= it;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      cmd_valid <= 1'b0;
      r = $urandom_range(0, 99);
      if (r < 60) repeat ($urandom_range(1, 2)) @(posedge clk);
      else if (r < 90) repeat ($urandom_range(3, 8)) @(posedge clk);
      else repeat ($urandom_range(15, 40)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  // hold off the sender until every expected event has arrived and the block is quiet
  task automatic wait_idle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input reg_index_t r, input logic [31:0] d);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    sb.write_reg(r, d);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] ivl, input logic [6:0] band,
                            input logic [15:0] dbn, input logic [31:0] mask);
    put_reg(REG_POT_INTERVAL, {16'd0, ivl});
    put_reg(REG_POT_DEADBAND, {25'd0, band});
    put_reg(REG_DEBOUNCE, {16'd0, dbn});
    put_reg(REG_BUTTON_ENABLE, mask);
    cfg_write <= 1'b0;
  endtask

  // mostly small steps, often right around the interval or the debounce time
  task automatic bump_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) clock_ms = clock_ms + $urandom_range(0, 3);
    else if (r < 80) clock_ms = clock_ms + sb.interval_ms + $urandom_range(0, 2) - 1;
    else if (r < 97) clock_ms = clock_ms + sb.hold_ms + $urandom_range(0, 2) - 1;
    else clock_ms = clock_ms + $urandom;
  endtask

  initial begin : stimulus
    logic [15:0] ivl;
    logic [6:0]  band;
    logic [15:0] dbn;
    logic [31:0] mask;
    logic [4:0]  idx;
    logic        lvl;
    logic        cw;
    logic [10:0] junk;
    int          kind;
    int          steps;
    int          seq_no;
    int          phase_end;

    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: first pot value of 0 stays under the deadband, full scale
    // is reported, a second sample inside the interval is dropped, an out of
    // range pot and a disabled button are ignored
    clock_ms = 32'd10;
    send_item(CMD_POT, 5'd0, 12'h000);
    clock_ms = 32'd20;
    send_item(CMD_POT, 5'd0, 12'hFFF);
    send_item(CMD_POT, 5'd0, 12'h000);
    send_item(CMD_POT, 5'd31, 12'hABC);
    send_item(CMD_BUTTON, 5'd3, 12'h000);
    // four clockwise steps, a skipped edge, no move, then two flushes (second empty)
    send_item(CMD_JOG_PHASE, 5'd31, 12'hFFE);
    send_item(CMD_JOG_PHASE, 5'd0, 12'h003);
    send_item(CMD_JOG_PHASE, 5'd7, 12'h801);
    send_item(CMD_JOG_PHASE, 5'd0, 12'h000);
    send_item(CMD_JOG_PHASE, 5'd0, 12'h003);
    send_item(CMD_JOG_PHASE, 5'd0, 12'h003);
    send_item(CMD_JOG_FLUSH, 5'd0, 12'h000);
    send_item(CMD_JOG_FLUSH, 5'd31, 12'hFFF);

    // everything at zero: zero deadband reports repeats, no debounce
    wait_idle();
    set_config(16'd0, 7'd0, 16'd0, 32'hFFFF_FFFF);
    send_item(CMD_POT, 5'd1, 12'h000);
    send_item(CMD_POT, 5'd1, 12'h01F);
    send_item(CMD_BUTTON, 5'd5, 12'hFFE);
    send_item(CMD_BUTTON, 5'd5, 12'h001);
    // three counter-clockwise steps from 11
    send_item(CMD_JOG_PHASE, 5'd0, 12'h002);
    send_item(CMD_JOG_PHASE, 5'd0, 12'h000);
    send_item(CMD_JOG_PHASE, 5'd0, 12'h001);
    send_item(CMD_JOG_FLUSH, 5'd0, 12'h000);
    wait_idle();

    // largest settings, with the time stamp wrapping between two pot reports
    set_config(16'hFFFF, 7'd127, 16'hFFFF, 32'h8000_0001);
    clock_ms = 32'hFFFF_FF00;
    send_item(CMD_POT, 5'd2, 12'hFFF);
    send_item(CMD_BUTTON, 5'd31, 12'h000);
    send_item(CMD_BUTTON, 5'd1, 12'h000);
    clock_ms = clock_ms + 32'd65535;
    send_item(CMD_POT, 5'd2, 12'h000);
    send_item(CMD_BUTTON, 5'd31, 12'h000);
    wheel_ab = 2'b01;

    // random phases, each with its own settings
    seq_no = 0;
    while (items_counted < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 4))
        0:       ivl = 16'd0;
        1:       ivl = 16'($urandom_range(1, 10));
        2:       ivl = 16'hFFFF;
        default: ivl = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       band = 7'd0;
        1:       band = 7'($urandom_range(1, 2));
        2:       band = 7'd127;
        default: band = 7'($urandom_range(0, 127));
      endcase
      case ($urandom_range(0, 4))
        0:       dbn = 16'd0;
        1:       dbn = 16'($urandom_range(1, 30));
        2:       dbn = 16'hFFFF;
        default: dbn = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       mask = 32'h0;
        1:       mask = 32'h5555_5555;
        2:       mask = $urandom;
        default: mask = 32'hFFFF_FFFF;
      endcase
      set_config(ivl, band, dbn, mask);
      phase_end = items_counted + $urandom_range(25, 50);
      while (items_counted < phase_end && items_counted < RANDOM_ITEMS) begin
        kind = (seq_no == 0) ? 60 : $urandom_range(0, 99);
        seq_no++;
        if (kind < 25) begin
          // pot sweep, now and then on a pot that does not exist
          idx = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31))
                                            : 5'($urandom_range(0, 15));
          repeat ($urandom_range(1, 4)) begin
            bump_time();
            send_item(CMD_POT, idx, 12'($urandom_range(0, 4095)));
          end
        end else if (kind < 50) begin
          // button change, sometimes with contact bounce, then held for about the debounce time
          idx = 5'($urandom_range(0, 31));
          repeat (3) if (!sb.button_on[idx]) idx = 5'($urandom_range(0, 31));
          lvl = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 2) == 0) begin
            junk = 11'($urandom);
            send_item(CMD_BUTTON, idx, {junk, ~lvl});
            clock_ms = clock_ms + $urandom_range(0, 3);
          end
          junk = 11'($urandom);
          send_item(CMD_BUTTON, idx, {junk, lvl});
          clock_ms = clock_ms + sb.hold_ms + $urandom_range(0, 2) - 1;
          junk = 11'($urandom);
          send_item(CMD_BUTTON, idx, {junk, lvl});
        end else if (kind < 75) begin
          // jog turn with the odd skipped edge or pause, then one or two flushes;
          // the first turn of the random part has more phase items than one burst holds
          cw = 1'($urandom_range(0, 1));
          steps = (seq_no == 1 || $urandom_range(0, 4) == 0) ? $urandom_range(66, 140)
                                                              : $urandom_range(1, 20);
          for (int k = 0; k < steps; k++) begin
            if ($urandom_range(0, 15) == 0) wheel_ab = wheel_ab ^ 2'b11;
            else if ($urandom_range(0, 15) != 0) wheel_ab = turn(wheel_ab, cw);
            junk = 11'($urandom);
            send_item(CMD_JOG_PHASE, 5'($urandom), {junk[9:0], wheel_ab});
          end
          send_item(CMD_JOG_FLUSH, 5'($urandom), 12'($urandom));
          if ($urandom_range(0, 2) == 0) send_item(CMD_JOG_FLUSH, 5'($urandom), 12'($urandom));
        end else if (kind < 92) begin
          // noise: any command, any fields, sometimes any time stamp
          if ($urandom_range(0, 3) == 0) clock_ms = $urandom;
          else bump_time();
          junk = 11'($urandom);
          idx = 5'($urandom);
          lvl = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 3))
            0: send_item(CMD_POT, idx, {junk, lvl});
            1: send_item(CMD_BUTTON, idx, {junk, lvl});
            2: begin
              wheel_ab = {junk[0], lvl};
              send_item(CMD_JOG_PHASE, idx, {junk, lvl});
            end
            default: send_item(CMD_JOG_FLUSH, idx, {junk, lvl});
          endcase
        end else begin
          // sender waits for the block to drain completely
          wait_idle();
        end
      end
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("control_surface_event_scanner_top: match");
    end else begin
      $display("control_surface_event_scanner_top: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
hdl/cses_pkg.sv
hdl/cses_ram.sv
hdl/control_surface_event_scanner_top.sv
tb/sv/control_surface_event_scanner_top_tb.sv
